// ===== rtl/crc8_stuffed_frame_builder_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the CRC8 stuffed frame builder
// Concurrent assertion wrappers used by csfb_shift.
// ---------------------------------------------------------------------------
`ifndef CRC8_STUFFED_FRAME_BUILDER_ASSERT_SVH
`define CRC8_STUFFED_FRAME_BUILDER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CSFB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CSFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/csfb_pkg.sv =====
// ---------------------------------------------------------------------------
// CRC8 stuffed frame builder package
// Frame constants, CRC8 step function and the byte list type.
// ---------------------------------------------------------------------------
package csfb_pkg;

   localparam logic [7:0] STUFF_MARK = 8'hD7;
   localparam logic [7:0] STUFF_FILL = 8'h00;
   localparam logic [7:0] HDR_B0     = 8'h00;
   localparam logic [7:0] HDR_B1     = 8'hD7;
   localparam logic [7:0] HDR_B2     = 8'h29;
   localparam logic [7:0] CRC_POLY   = 8'h3C;
   localparam logic [7:0] CRC_INIT   = 8'h00;

   localparam int unsigned LIST_DEPTH = 7;
   localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);

   // xor the byte, rotate right by one, fold in the polynomial on a set top bit
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      c = {c[0], c[7:1]};
      if (c[7]) begin
         c = c ^ CRC_POLY;
      end
      return c;
   endfunction

   localparam logic [7:0] HDR_CRC =
      crc8_step(crc8_step(crc8_step(CRC_INIT, HDR_B0), HDR_B1), HDR_B2);

   typedef struct packed {
      logic [LIST_DEPTH-1:0][7:0] bytes;  // bytes[0] goes out first
      logic [CNT_W-1:0]           count;
      logic                       last;   // list closes the frame
   } list_type;

endpackage

// ===== rtl/csfb_expand.sv =====
// ---------------------------------------------------------------------------
// CRC8 stuffed frame builder - item expansion
// Turns one body byte into its list of line bytes and keeps the CRC state.
// ---------------------------------------------------------------------------
module csfb_expand (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         in_byte,
   input  logic               in_end,
   input  logic               load,
   output csfb_pkg::list_type list
);
   import csfb_pkg::*;

   logic [7:0]       crc_ff, crc_in;
   logic             inside_ff, inside_in;
   logic [7:0]       crc_start;
   logic [7:0]       crc_new;
   logic [CNT_W-1:0] pos;

   assign crc_start = inside_ff ? crc_ff : HDR_CRC;
   assign crc_new   = crc8_step(crc_start, in_byte);

   always_comb begin
      list = '0;
      pos  = '0;
      if (!inside_ff) begin
         list.bytes[0] = HDR_B0;
         list.bytes[1] = HDR_B1;
         list.bytes[2] = HDR_B2;
         pos = CNT_W'(3);
      end
      list.bytes[pos] = in_byte;
      pos = pos + CNT_W'(1);
      if (in_byte == STUFF_MARK) begin
         list.bytes[pos] = STUFF_FILL;
         pos = pos + CNT_W'(1);
      end
      if (in_end) begin
         list.bytes[pos] = crc_new;
         pos = pos + CNT_W'(1);
         if (crc_new == STUFF_MARK) begin
            list.bytes[pos] = STUFF_FILL;
            pos = pos + CNT_W'(1);
         end
      end
      list.count = pos;
      list.last  = in_end;
   end

   // on a load, clear the CRC at frame end, advance it otherwise
   always_comb begin
      crc_in    = crc_ff;
      inside_in = inside_ff;
      if (load) begin
         crc_in    = in_end ? CRC_INIT : crc_new;
         inside_in = !in_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff    <= CRC_INIT;
         inside_ff <= 1'b0;
      end else begin
         crc_ff    <= crc_in;
         inside_ff <= inside_in;
      end
   end

endmodule

// ===== rtl/csfb_shift.sv =====
// ---------------------------------------------------------------------------
// CRC8 stuffed frame builder - byte list shifter
// Holds one item's byte list and moves it out a byte per cycle into the
// result register whenever that register is free.
// ---------------------------------------------------------------------------
`include "crc8_stuffed_frame_builder_assert.svh"

module csfb_shift (
   input  logic               clock,
   input  logic               reset,
   input  logic               list_valid,
   input  csfb_pkg::list_type list,
   output logic               load,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_byte,
   output logic               out_last
);
   import csfb_pkg::*;

   logic [LIST_DEPTH-1:0][7:0] bytes_ff, bytes_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       last_ff, last_in;
   logic                       valid_ff, valid_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       flag_ff, flag_in;
   logic                       out_free;
   logic                       emit;

   assign out_free = !valid_ff || out_ready;
   assign emit     = (cnt_ff != '0) && out_free;
   // take the next list while the current one is empty or sends its final byte
   assign load     = list_valid && ((cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && emit));

   always_comb begin
      bytes_in = bytes_ff;
      cnt_in   = cnt_ff;
      last_in  = last_ff;
      if (emit) begin
         bytes_in = bytes_ff >> 8;
         cnt_in   = cnt_ff - CNT_W'(1);
      end
      if (load) begin
         bytes_in = list.bytes;
         cnt_in   = list.count;
         last_in  = list.last;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      flag_in  = flag_ff;
      if (emit) begin
         valid_in = 1'b1;
         byte_in  = bytes_ff[0];
         flag_in  = last_ff && (cnt_ff == CNT_W'(1));
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff <= bytes_in;
      byte_ff  <= byte_in;
      flag_ff  <= flag_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = flag_ff;

   `CSFB_ASSERT_NOW(a_load_when_drained, clock, reset, load,
      (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && emit), "list overwritten before drained")
   `CSFB_ASSERT_NEXT(a_count_steps, clock, reset, emit && !load,
      cnt_ff == $past(cnt_ff) - CNT_W'(1), "byte count did not step down on emit")
   `CSFB_ASSERT_NOW(a_end_list_has_crc, clock, reset, load && list.last,
      list.count >= CNT_W'(2), "frame end list lacks body or CRC byte")
   `CSFB_ASSERT_NOW(a_list_nonempty, clock, reset, load,
      list.count != '0, "empty byte list loaded")

endmodule

// ===== rtl/crc8_stuffed_frame_builder.sv =====
// Each accepted body byte produces 1 to 7 line bytes, sent one per clock
// cycle unless rsp_tready stalls: the header 00 D7 29 before the first
// body byte of a frame, the body byte, a 00 after any D7, and at frame end
// the CRC8 (with its own 00 if it equals D7). The single byte-wide result
// register sets the rate: a mid-frame byte other than D7 gives one line
// byte, so items stream at one per cycle unless stalled; a frame of N body
// bytes with S stuffed bytes gives N + S + 4 line bytes. The next item is
// taken in the cycle the previous item's last byte moves out.
// ---------------------------------------------------------------------------
// CRC8 stuffed frame builder
// Frames body bytes with header, byte stuffing and a trailing CRC8.
// ---------------------------------------------------------------------------
module crc8_stuffed_frame_builder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] body_byte
   input  logic       req_tlast,   // frame_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // frame_last
);
   import csfb_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       load;
   list_type   list;

   // hold the item until its byte list is taken
   assign req_tready  = !in_valid_ff || load;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !load);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
   end

   csfb_expand u_expand (
      .clock   (clock),
      .reset   (reset),
      .in_byte (in_byte_ff),
      .in_end  (in_end_ff),
      .load    (load),
      .list    (list)
   );

   csfb_shift u_shift (
      .clock      (clock),
      .reset      (reset),
      .list_valid (in_valid_ff),
      .list       (list),
      .load       (load),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_last   (rsp_tlast)
   );

endmodule

// ===== tb/sv/crc8_stuffed_frame_builder_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// CRC8 stuffed frame builder testbench
// Streams body bytes into the framer and predicts every line byte: header,
// stuffed body, CRC8 and its stuffing. Line bytes are checked in order
// against the prediction under random stalls on both sides.
// ---------------------------------------------------------------------------
module crc8_stuffed_frame_builder_tb;
   import csfb_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned ITEMS_PER_PHASE = 85;

   typedef struct packed {
      logic [7:0] value;
      logic       last;
   } line_byte_type;

   // Predicts the line bytes of each body byte and checks them in order.
   class line_byte_tracker;
      line_byte_type expected_line[$];
      logic [7:0] frame_crc;
      logic       in_frame;
      int         mismatches;
      int         errors;

      function new();
         frame_crc  = CRC_INIT;
         in_frame   = 1'b0;
         mismatches = 0;
         errors     = 0;
      endfunction

      function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
         logic [7:0] x;
         x = crc ^ b;
         x = {x[0], x[7:1]};
         if (x[7]) begin
            x = x ^ CRC_POLY;
         end
         return x;
      endfunction

      function void push_line(input logic [7:0] value, input logic last);
         line_byte_type lb;
         lb.value = value;
         lb.last  = last;
         expected_line.push_back(lb);
      endfunction

      // CRC the next body byte would start from
      function logic [7:0] base_crc();
         if (in_frame) begin
            return frame_crc;
         end
         return crc_fold(crc_fold(crc_fold(CRC_INIT, HDR_B0), HDR_B1), HDR_B2);
      endfunction

      // body byte that brings the frame CRC to the given value
      function logic [7:0] byte_for_crc(input logic [7:0] target);
         logic [7:0] base;
         base = base_crc();
         for (int x = 0; x < 256; x++) begin
            if (crc_fold(base, x[7:0]) == target) begin
               return x[7:0];
            end
         end
         return 8'h00;
      endfunction

      function void note_body_byte(input logic [7:0] b, input logic frame_end);
         if (!in_frame) begin
            push_line(HDR_B0, 1'b0);
            push_line(HDR_B1, 1'b0);
            push_line(HDR_B2, 1'b0);
            frame_crc = base_crc();
            in_frame  = 1'b1;
         end
         push_line(b, 1'b0);
         if (b == STUFF_MARK) begin
            push_line(STUFF_FILL, 1'b0);
         end
         frame_crc = crc_fold(frame_crc, b);
         if (frame_end) begin
            if (frame_crc == STUFF_MARK) begin
               push_line(frame_crc, 1'b0);
               push_line(STUFF_FILL, 1'b1);
            end else begin
               push_line(frame_crc, 1'b1);
            end
            frame_crc = CRC_INIT;
            in_frame  = 1'b0;
         end
      endfunction

      function void check_line_byte(input logic [7:0] value, input logic last);
         line_byte_type lb;
         if (expected_line.size() == 0) begin
            errors++;
            if (errors + mismatches <= 10) begin
               $display("unexpected line byte %02h last %b", value, last);
            end
            return;
         end
         lb = expected_line.pop_front();
         if (value !== lb.value || last !== lb.last) begin
            mismatches++;
            if (errors + mismatches <= 10) begin
               $display("line byte mismatch: expected %02h last %b, got %02h last %b",
                        lb.value, lb.last, value, last);
            end
         end
      endfunction

      function int pending();
         return expected_line.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] body_byte
   logic       req_tlast = 1'b0;    // frame_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;           // frame_last

   int unsigned send_idle_pct = 30;
   int unsigned recv_idle_pct = 79;
   int unsigned cycle_count = 0;
   line_byte_tracker tracker;

   crc8_stuffed_frame_builder u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("crc8_stuffed_frame_builder_tb: done, errors");
      $finish;
   end

   // check line bytes and pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.check_line_byte(rsp_tdata, rsp_tlast);
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_item(input logic [7:0] b, input logic frame_end);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= frame_end;
      do begin
         @(posedge clock);
      end while (!req_tready);
      tracker.note_body_byte(b, frame_end);
   endtask

   // hold off the sender until every predicted line byte is out
   task automatic drain_line();
      req_tvalid <= 1'b0;
      while (tracker.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic send_random_frame(output int unsigned sent);
      int unsigned len;
      logic        force_mark;
      logic [7:0]  b;
      len = ($urandom_range(99) < 5) ? $urandom_range(60, 30) : $urandom_range(8, 1);
      force_mark = ($urandom_range(5) == 0);
      for (int unsigned i = 0; i < len; i++) begin
         if (i == len - 1 && force_mark) begin
            b = tracker.byte_for_crc(STUFF_MARK);
         end else if ($urandom_range(3) == 0) begin
            b = STUFF_MARK;
         end else begin
            b = 8'($urandom_range(255));
         end
         send_item(b, i == len - 1);
      end
      sent = len;
   endtask

   task automatic run_phase(input int unsigned s_pct, input int unsigned r_pct);
      int unsigned start;
      int unsigned sent;
      logic        paused;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      start  = 0;
      paused = 1'b0;
      while (start < ITEMS_PER_PHASE) begin
         send_random_frame(sent);
         start = start + sent;
         if (!paused && start > ITEMS_PER_PHASE / 2) begin
            drain_line();
            paused = 1'b1;
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single-byte frames at the extremes, a stuffed one and a D7 CRC
      send_item(8'h00, 1'b1);
      send_item(8'hFF, 1'b1);
      send_item(STUFF_MARK, 1'b1);
      send_item(tracker.byte_for_crc(STUFF_MARK), 1'b1);
      // header pattern in the body gets stuffed there
      send_item(HDR_B0, 1'b0);
      send_item(HDR_B1, 1'b0);
      send_item(HDR_B2, 1'b1);
      send_item(STUFF_MARK, 1'b0);
      send_item(STUFF_MARK, 1'b0);
      send_item(STUFF_MARK, 1'b1);
      send_item(8'h55, 1'b0);
      send_item(8'hAA, 1'b0);
      send_item(8'h01, 1'b0);
      send_item(8'hFE, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h7F, 1'b0);
      send_item(tracker.byte_for_crc(STUFF_MARK), 1'b1);
      send_item(8'h12, 1'b0);
      send_item(8'h34, 1'b0);
      send_item(STUFF_MARK, 1'b1);

      run_phase(30, 79);
      run_phase(79, 30);
      run_phase(0, 0);

      drain_line();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.mismatches == 0 && tracker.pending() == 0) begin
         $display("crc8_stuffed_frame_builder_tb: done, clean");
      end else begin
         $display("crc8_stuffed_frame_builder_tb: done, errors");
      end
      $finish;
   end

endmodule
